### sv/led_effect_sequencer_macros.svh
`ifndef LED_EFFECT_SEQUENCER_MACROS_SVH
`define LED_EFFECT_SEQUENCER_MACROS_SVH

// same-cycle implication, clocked on the rising edge, off while reset is high
`define LES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("les_checker: same-cycle implication failed");

// next-cycle implication, clocked on the rising edge, off while reset is high
`define LES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("les_checker: next-cycle implication failed");

`endif

### sv/les_pkg.sv
package les_pkg;

   localparam int DEFAULT_CURVE_STEPS = 500;
   localparam int DUR_W               = 32;
   localparam int LEVEL_W             = 8;
   localparam int CURVE_W             = 16;
   localparam int REQ_DATA_W          = 48;
   localparam int RSP_DATA_W          = 16;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_ON       = 3'd1,
      OP_OFF      = 3'd2,
      OP_FADE_ON  = 3'd3,
      OP_FADE_OFF = 3'd4,
      OP_BLINK    = 3'd5,
      OP_BREATHE  = 3'd6,
      OP_SET_PEAK = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'd0,
      MODE_ON       = 3'd1,
      MODE_FADE_ON  = 3'd2,
      MODE_FADE_OFF = 3'd3,
      MODE_BLINK    = 3'd4,
      MODE_BREATHE  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      WAVE_GAUSS    = 2'd0,
      WAVE_CIRCLE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_NONE     = 2'd3
   } wave_type;

endpackage

### sv/les_curve_rom.sv
module les_curve_rom #(
   parameter int CURVE_STEPS = les_pkg::DEFAULT_CURVE_STEPS,
   localparam int PHASE_W    = $clog2(CURVE_STEPS + 1)
) (
   input  logic                          clock,
   input  les_pkg::wave_type             rd_wave,
   input  logic [PHASE_W-1:0]            rd_phase,
   output logic [les_pkg::CURVE_W-1:0]   rd_data
);

   localparam int SPAN      = CURVE_STEPS + 1;
   localparam int ROM_DEPTH = 3 * SPAN;
   localparam int ADDR_W    = $clog2(ROM_DEPTH);

   localparam logic [63:0] S64       = 64'(CURVE_STEPS);
   localparam logic [63:0] SS64      = S64 * S64;
   localparam logic [63:0] Q30       = 64'd1 << 30;
   localparam logic [63:0] GAUSS_DEN = 64'd98 * SS64 * 64'd16;

   typedef logic [les_pkg::CURVE_W-1:0] table_type [ROM_DEPTH];

   function automatic logic [les_pkg::CURVE_W-1:0] to_entry(input logic [63:0] k);
      logic [les_pkg::CURVE_W-1:0] r;
      if (k == 64'd0) begin
         r = '0;
      end else if (k > 64'd65536) begin
         r = '1;
      end else begin
         r = les_pkg::CURVE_W'(k - 64'd1);
      end
      return r;
   endfunction

   function automatic table_type build_table();
      table_type   tbl;
      logic [63:0] twice, e, e2, u, term, prod, pos, neg, x, g, v, rt, rem, bit_w, k;
      int          p, n, i;
      for (p = 0; p < SPAN; p++) begin
         twice = 64'(2 * p);
         e     = (twice >= S64) ? twice - S64 : S64 - twice;
         e2    = e * e;
         // gaussian: Taylor sum of exp(-t/16), then square four times
         u    = (e2 * 64'd625 * Q30) / GAUSS_DEN;
         term = Q30;
         pos  = Q30;
         neg  = 64'd0;
         for (n = 1; n <= 12; n++) begin
            prod = (term * u) >> 30;
            case (n)
               2:       term = prod / 2;
               3:       term = prod / 3;
               4:       term = prod / 4;
               5:       term = prod / 5;
               6:       term = prod / 6;
               7:       term = prod / 7;
               8:       term = prod / 8;
               9:       term = prod / 9;
               10:      term = prod / 10;
               11:      term = prod / 11;
               12:      term = prod / 12;
               default: term = prod;
            endcase
            if ((n & 1) != 0) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         x = (pos > neg) ? pos - neg : 64'd0;
         for (i = 0; i < 4; i++) begin
            x = (x * x) >> 30;
         end
         g = (x + 64'd16383) >> 14;
         tbl[p] = to_entry(g);
         // circular: ceiling square root of the scaled fraction
         v     = (((SS64 - e2) << 32) + SS64 - 64'd1) / SS64;
         rt    = 64'd0;
         rem   = v;
         bit_w = 64'd1 << 32;
         for (i = 0; i < 17; i++) begin
            if (rem >= rt + bit_w) begin
               rem = rem - (rt + bit_w);
               rt  = (rt >> 1) + bit_w;
            end else begin
               rt = rt >> 1;
            end
            bit_w = bit_w >> 2;
         end
         if (rt * rt < v) begin
            rt = rt + 64'd1;
         end
         tbl[SPAN + p] = to_entry(rt);
         // triangle
         k = (64'd65536 * (S64 - e) + S64 - 64'd1) / S64;
         tbl[2 * SPAN + p] = to_entry(k);
      end
      return tbl;
   endfunction

   localparam table_type CURVE_TABLE = build_table();

   logic [ADDR_W-1:0]              base;
   logic [ADDR_W-1:0]              rd_addr;
   logic [les_pkg::CURVE_W-1:0]    rd_data_ff;

   always_comb begin
      unique case (rd_wave)
         les_pkg::WAVE_CIRCLE:   base = ADDR_W'(SPAN);
         les_pkg::WAVE_TRIANGLE: base = ADDR_W'(2 * SPAN);
         default:                base = '0;
      endcase
   end

   assign rd_addr = base + ADDR_W'(rd_phase);

   always_ff @(posedge clock) begin
      rd_data_ff <= CURVE_TABLE[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/led_effect_sequencer.sv
// LED effect sequencer.
// Input channel req_*: one transfer is a 1 ms tick or a command, chosen by
// req_tuser (opcode). Result channel rsp_*: exactly one transfer per input
// transfer, carrying the PWM duty now driven, whether this item wrote it, and
// the mode after the item.
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one item per cycle while results are taken; the state update,
// the fade multiply and the interval division each finish in the cycle of
// the transfer. The curve memory is read at the address that the updated
// state selects, so its registered data is ready when the next item arrives.
// Reset: synchronous; mode off, duty 0, peak 255, phase 0, gaussian curve.
// req_tready is low while reset is high.
// Stall: a result not taken holds on rsp_*; req_tready drops until it is taken,
// and rises again in the cycle rsp_tready is seen, so transfers keep flowing.
module led_effect_sequencer #(
   parameter int CURVE_STEPS = les_pkg::DEFAULT_CURVE_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // duration [31:0], waveform [33:32], level [41:34], zero fill [47:42]
   input  logic [les_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode [2:0]
   input  logic [2:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // duty [7:0], mode [10:8], zero fill [15:11]
   output logic [les_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // duty_written [0]
   output logic [0:0]                        rsp_tuser
);

   localparam int PHASE_W   = $clog2(CURVE_STEPS + 1);
   localparam int DIV_SHIFT = 33 + $clog2(CURVE_STEPS);
   localparam logic [63:0] DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(CURVE_STEPS) - 64'd1) / 64'(CURVE_STEPS);
   localparam logic [33:0]        RECIP  = 34'(DIV_RECIP);
   localparam logic [PHASE_W-1:0] PH_END = PHASE_W'(CURVE_STEPS);
   localparam logic [PHASE_W-1:0] PH_MID = PHASE_W'(CURVE_STEPS / 2);

   localparam int DW = les_pkg::DUR_W;
   localparam int LW = les_pkg::LEVEL_W;

   les_pkg::mode_type     mode_ff, mode_in;
   logic [DW-1:0]         elapsed_ff, elapsed_in;
   logic [DW-1:0]         interval_ff, interval_in;
   logic [LW-1:0]         stored_ff, stored_in;
   logic [LW-1:0]         peak_ff, peak_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   les_pkg::wave_type     wave_ff, wave_in;
   logic [LW-1:0]         pwm_ff, pwm_in;
   logic                  written_ff, written_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                          accept;
   les_pkg::opcode_type           opcode;
   logic [DW-1:0]                 duration;
   les_pkg::wave_type             waveform;
   logic [LW-1:0]                 level;
   logic [DW-1:0]                 elapsed_inc;
   logic [32:0]                   div_num;
   logic [66:0]                   div_prod;
   logic [DW-1:0]                 div_q;
   logic [DW-1:0]                 div_interval;
   logic [les_pkg::CURVE_W-1:0]   curve_data;
   logic [16:0]                   curve_plus1;
   logic [24:0]                   fade_prod;
   logic [LW-1:0]                 fade_lvl;
   logic [LW-1:0]                 blink_lvl;
   logic [PHASE_W-1:0]            phase_step;
   les_pkg::wave_type             rd_wave;
   logic [PHASE_W-1:0]            rd_phase;

   assign opcode   = les_pkg::opcode_type'(req_tuser);
   assign duration = req_tdata[31:0];
   assign waveform = les_pkg::wave_type'(req_tdata[33:32]);
   assign level    = req_tdata[41:34];

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign elapsed_inc = elapsed_ff + 32'd1;

   // divide the duration (doubled for a fade) by the step count through a reciprocal multiply
   assign div_num      = (opcode == les_pkg::OP_BREATHE) ? {1'b0, duration} : {duration, 1'b0};
   assign div_prod     = 67'(div_num) * 67'(RECIP);
   assign div_q        = 32'(div_prod >> DIV_SHIFT);
   assign div_interval = (div_q == '0) ? 32'd1 : div_q;

   assign curve_plus1 = {1'b0, curve_data} + 17'd1;
   assign fade_prod   = 25'(peak_ff) * 25'(curve_plus1);
   assign fade_lvl    = (wave_ff == les_pkg::WAVE_NONE) ? '0 : fade_prod[23:16];
   assign phase_step  = (phase_ff >= PH_END) ? '0 : PHASE_W'(phase_ff + 1'b1);
   assign blink_lvl   = (stored_ff != '0) ? '0 : peak_ff;

   always_comb begin
      mode_in     = mode_ff;
      elapsed_in  = elapsed_ff;
      interval_in = interval_ff;
      stored_in   = stored_ff;
      peak_in     = peak_ff;
      phase_in    = phase_ff;
      wave_in     = wave_ff;
      pwm_in      = pwm_ff;
      written_in  = written_ff;
      if (accept) begin
         written_in = 1'b0;
         unique case (opcode) inside
            les_pkg::OP_TICK: begin
               if (elapsed_inc >= interval_ff) begin
                  elapsed_in = '0;
                  if (interval_ff != '0) begin
                     unique case (mode_ff)
                        les_pkg::MODE_ON: begin
                           mode_in    = les_pkg::MODE_OFF;
                           pwm_in     = '0;
                           written_in = 1'b1;
                        end
                        les_pkg::MODE_FADE_ON: begin
                           stored_in  = fade_lvl;
                           pwm_in     = fade_lvl;
                           written_in = 1'b1;
                           phase_in   = phase_step;
                           if ({phase_step, 1'b0} >= (PHASE_W + 1)'(CURVE_STEPS)) begin
                              interval_in = '0;
                              mode_in     = les_pkg::MODE_ON;
                           end
                        end
                        les_pkg::MODE_FADE_OFF: begin
                           stored_in  = fade_lvl;
                           pwm_in     = fade_lvl;
                           written_in = 1'b1;
                           phase_in   = phase_step;
                           if (phase_step >= PH_END) begin
                              interval_in = '0;
                              mode_in     = les_pkg::MODE_OFF;
                           end
                        end
                        les_pkg::MODE_BLINK: begin
                           stored_in  = blink_lvl;
                           pwm_in     = blink_lvl;
                           written_in = 1'b1;
                        end
                        les_pkg::MODE_BREATHE: begin
                           stored_in  = fade_lvl;
                           pwm_in     = fade_lvl;
                           written_in = 1'b1;
                           phase_in   = phase_step;
                        end
                        default: begin
                        end
                     endcase
                  end
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
            les_pkg::OP_ON: begin
               mode_in     = les_pkg::MODE_ON;
               pwm_in      = peak_ff;
               written_in  = 1'b1;
               interval_in = duration;
               elapsed_in  = '0;
            end
            les_pkg::OP_OFF: begin
               mode_in    = les_pkg::MODE_OFF;
               pwm_in     = '0;
               written_in = 1'b1;
            end
            les_pkg::OP_FADE_ON, les_pkg::OP_FADE_OFF: begin
               wave_in     = waveform;
               interval_in = div_interval;
               if (opcode == les_pkg::OP_FADE_ON) begin
                  mode_in  = les_pkg::MODE_FADE_ON;
                  phase_in = '0;
               end else begin
                  mode_in  = les_pkg::MODE_FADE_OFF;
                  phase_in = PH_MID;
               end
            end
            les_pkg::OP_BLINK: begin
               mode_in     = les_pkg::MODE_BLINK;
               elapsed_in  = '0;
               stored_in   = blink_lvl;
               pwm_in      = blink_lvl;
               written_in  = 1'b1;
               interval_in = duration;
            end
            les_pkg::OP_BREATHE: begin
               mode_in     = les_pkg::MODE_BREATHE;
               wave_in     = waveform;
               interval_in = div_interval;
            end
            default: begin
               peak_in = level;
               if (stored_ff >= level) begin
                  stored_in  = level;
                  pwm_in     = level;
                  written_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= les_pkg::MODE_OFF;
         elapsed_ff   <= '0;
         interval_ff  <= '0;
         stored_ff    <= '0;
         peak_ff      <= 8'd255;
         phase_ff     <= '0;
         wave_ff      <= les_pkg::WAVE_GAUSS;
         pwm_ff       <= '0;
         written_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         interval_ff  <= interval_in;
         stored_ff    <= stored_in;
         peak_ff      <= peak_in;
         phase_ff     <= phase_in;
         wave_ff      <= wave_in;
         pwm_ff       <= pwm_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // fetch the curve entry for the state that the next item will see
   assign rd_wave  = reset ? les_pkg::WAVE_GAUSS : wave_in;
   assign rd_phase = reset ? '0 : phase_in;

   les_curve_rom #(
      .CURVE_STEPS (CURVE_STEPS)
   ) u_curve_rom (
      .clock    (clock),
      .rd_wave  (rd_wave),
      .rd_phase (rd_phase),
      .rd_data  (curve_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, mode_ff, pwm_ff};
   assign rsp_tuser  = written_ff;

endmodule

### sv/les_checker.sv
`include "led_effect_sequencer_macros.svh"

module les_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [2:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [les_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   logic                          req_xfer;
   logic                          rsp_stall;
   logic [les_pkg::RSP_DATA_W:0]  rsp_word;
   logic                          rsp_off_shown;
   logic                          rsp_on_shown;

   assign req_xfer      = req_tvalid && req_tready;
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_word      = {rsp_tuser, rsp_tdata};
   assign rsp_off_shown = rsp_tvalid && rsp_tuser[0] && (rsp_tdata[7:0] == 8'd0) &&
                          (rsp_tdata[10:8] == les_pkg::MODE_OFF);
   assign rsp_on_shown  = rsp_tvalid && rsp_tuser[0] && (rsp_tdata[10:8] == les_pkg::MODE_ON);

   `LES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   `LES_ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_stall, !req_tready)

   `LES_ASSERT_NEXT(a_off_result, clock, reset, req_xfer && (req_tuser == les_pkg::OP_OFF), rsp_off_shown)

   `LES_ASSERT_NEXT(a_on_result, clock, reset, req_xfer && (req_tuser == les_pkg::OP_ON), rsp_on_shown)

endmodule

bind led_effect_sequencer les_checker u_les_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### bench/tb.sv
module tb;

   localparam int STEPS = les_pkg::DEFAULT_CURVE_STEPS;
   localparam int SPAN  = STEPS + 1;

   typedef struct {
      les_pkg::opcode_type op;
      bit [31:0]           dur;
      bit [1:0]            wave;
      bit [7:0]            lvl;
      bit                  drain;
   } led_cmd_type;

   typedef struct {
      bit [7:0]          duty;
      bit                written;
      les_pkg::mode_type mode;
   } led_out_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [les_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [les_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                     rsp_tuser;

   led_cmd_type led_cmds[$];
   led_out_type led_outs_due[$];
   bit [15:0] shape_table [0:3*SPAN-1];

   les_pkg::mode_type fx_mode;
   bit [31:0]         fx_elapsed;
   bit [31:0]         fx_interval;
   bit [7:0]          fx_level;
   bit [7:0]          fx_peak;
   int unsigned       fx_phase;
   les_pkg::wave_type fx_wave;
   bit [7:0]          fx_duty;
   bit                fx_wrote;

   bit          req_fire = 1'b0;
   led_cmd_type drv_cmd;
   int          src_gap = 0;
   int          sink_wait = 0;
   bit          long_hold_done = 1'b0;
   int          rsp_count = 0;
   int          fail_count = 0;

   led_effect_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit [15:0] frac_code(longint unsigned k);
      if (k == 0) return 16'd0;
      if (k > 65536) return 16'hFFFF;
      return 16'(k - 1);
   endfunction

   function automatic bit idle_ok();
      return led_cmds.size() >= 150 && (led_cmds.size() % 400) >= 100;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // one fade or breathe step: scale the peak by the curve fraction, advance the phase
   function automatic void curve_step();
      int unsigned ph;
      bit [31:0]   code;
      bit [7:0]    lv;
      ph = fx_phase > STEPS ? STEPS : fx_phase;
      lv = 8'd0;
      if (fx_wave != les_pkg::WAVE_NONE) begin
         code = 32'(shape_table[int'(fx_wave) * SPAN + ph]);
         lv = 8'(((32'(fx_peak)) * (code + 32'd1)) >> 16);
      end
      fx_level = lv;
      fx_duty = lv;
      fx_wrote = 1'b1;
      fx_phase = ph >= STEPS ? 0 : ph + 1;
   endfunction

   function automatic void apply_led_item(les_pkg::opcode_type op, bit [31:0] dur,
                                          bit [1:0] wave, bit [7:0] lvl);
      bit [63:0]   q;
      led_out_type res;
      fx_wrote = 1'b0;
      case (op)
         les_pkg::OP_TICK: begin
            fx_elapsed = fx_elapsed + 32'd1;
            if (fx_elapsed >= fx_interval) begin
               fx_elapsed = 32'd0;
               if (fx_interval != 0) begin
                  case (fx_mode)
                     les_pkg::MODE_ON: begin
                        fx_mode = les_pkg::MODE_OFF;
                        fx_duty = 8'd0;
                        fx_wrote = 1'b1;
                     end
                     les_pkg::MODE_FADE_ON: begin
                        curve_step();
                        if (2 * fx_phase >= STEPS) begin
                           fx_interval = 32'd0;
                           fx_mode = les_pkg::MODE_ON;
                        end
                     end
                     les_pkg::MODE_FADE_OFF: begin
                        curve_step();
                        if (fx_phase >= STEPS) begin
                           fx_interval = 32'd0;
                           fx_mode = les_pkg::MODE_OFF;
                        end
                     end
                     les_pkg::MODE_BLINK: begin
                        fx_level = fx_level != 0 ? 8'd0 : fx_peak;
                        fx_duty = fx_level;
                        fx_wrote = 1'b1;
                     end
                     les_pkg::MODE_BREATHE: curve_step();
                     default: ;
                  endcase
               end
            end
         end
         les_pkg::OP_ON: begin
            fx_mode = les_pkg::MODE_ON;
            fx_duty = fx_peak;
            fx_wrote = 1'b1;
            fx_interval = dur;
            fx_elapsed = 32'd0;
         end
         les_pkg::OP_OFF: begin
            fx_mode = les_pkg::MODE_OFF;
            fx_duty = 8'd0;
            fx_wrote = 1'b1;
         end
         les_pkg::OP_FADE_ON, les_pkg::OP_FADE_OFF: begin
            fx_mode = op == les_pkg::OP_FADE_ON ? les_pkg::MODE_FADE_ON : les_pkg::MODE_FADE_OFF;
            fx_wave = les_pkg::wave_type'(wave);
            q = (64'(dur) * 64'd2) / 64'(STEPS);
            fx_interval = q < 1 ? 32'd1 : q[31:0];
            fx_phase = op == les_pkg::OP_FADE_ON ? 0 : STEPS / 2;
         end
         les_pkg::OP_BLINK: begin
            fx_mode = les_pkg::MODE_BLINK;
            fx_elapsed = 32'd0;
            fx_level = fx_level != 0 ? 8'd0 : fx_peak;
            fx_duty = fx_level;
            fx_wrote = 1'b1;
            fx_interval = dur;
         end
         les_pkg::OP_BREATHE: begin
            fx_mode = les_pkg::MODE_BREATHE;
            fx_wave = les_pkg::wave_type'(wave);
            q = 64'(dur) / 64'(STEPS);
            fx_interval = q < 1 ? 32'd1 : q[31:0];
         end
         les_pkg::OP_SET_PEAK: begin
            fx_peak = lvl;
            if (fx_level >= fx_peak) begin
               fx_level = fx_peak;
               fx_duty = fx_level;
               fx_wrote = 1'b1;
            end
         end
      endcase
      res.duty = fx_duty;
      res.written = fx_wrote;
      res.mode = fx_mode;
      led_outs_due.push_back(res);
   endfunction

   task automatic add_cmd(les_pkg::opcode_type op, bit [31:0] dur, bit [1:0] wave,
                          bit [7:0] lvl, bit drain);
      led_cmd_type c;
      c.op = op;
      c.dur = dur;
      c.wave = wave;
      c.lvl = lvl;
      c.drain = drain;
      led_cmds.push_back(c);
   endtask

   // drive: new item at the falling edge once the previous one has transferred
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (src_gap != 0) begin
               src_gap <= src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (led_cmds.size() != 0 &&
                         !(led_cmds[0].drain && led_outs_due.size() != 0)) begin
               drv_cmd = led_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= drv_cmd.op;
               req_tdata <= {6'b0, drv_cmd.lvl, drv_cmd.wave, drv_cmd.dur};
               if (idle_ok() && $urandom_range(0, 6) == 0) begin
                  src_gap <= $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // accept results; one long hold-off fills the block and stalls its input
   always @(negedge clock) begin
      if (!reset) begin
         if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && rsp_count >= 600) begin
            long_hold_done <= 1'b1;
            sink_wait <= 59;
            rsp_tready <= 1'b0;
         end else if (idle_ok() && $urandom_range(0, 6) == 0) begin
            sink_wait <= $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      led_out_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (led_outs_due.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, actual duty %0d written %0d mode %0d",
                        $time, rsp_tdata[7:0], rsp_tuser[0], rsp_tdata[10:8]);
            end else begin
               want = led_outs_due.pop_front();
               check_field("duty", want.duty, rsp_tdata[7:0]);
               check_field("duty_written", want.written, rsp_tuser[0]);
               check_field("mode", int'(want.mode), rsp_tdata[10:8]);
            end
         end
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            apply_led_item(les_pkg::opcode_type'(req_tuser), req_tdata[31:0],
                           req_tdata[33:32], req_tdata[41:34]);
         end
      end
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      longint unsigned     s, ss, tw, e, e2, u, term, pos, neg, x, k, v, rem, r, b, n;
      int                  p, pick, runs;
      les_pkg::opcode_type op;
      bit [31:0]           dur;
      bit                  mid_drained;

      // curve fractions: gaussian, circular, triangle
      s = STEPS;
      ss = s * s;
      for (p = 0; p <= STEPS; p++) begin
         tw = 2 * longint'(p);
         e = tw >= s ? tw - s : s - tw;
         e2 = e * e;
         u = (e2 * 625 * (64'd1 << 30)) / (98 * ss * 16);
         term = 64'd1 << 30;
         pos = term;
         neg = 0;
         for (n = 1; n <= 12; n++) begin
            term = (term * u) / (n << 30);
            if (n % 2 == 1) neg += term;
            else pos += term;
         end
         x = pos > neg ? pos - neg : 0;
         repeat (4) x = (x * x) >> 30;
         shape_table[p] = frac_code((x + 16383) >> 14);

         v = (((ss - e2) << 32) + ss - 1) / ss;
         rem = v;
         r = 0;
         b = 64'd1 << 62;
         while (b > rem) b >>= 2;
         while (b != 0) begin
            if (rem >= r + b) begin
               rem -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         if (r * r < v) r++;
         shape_table[SPAN + p] = frac_code(r);

         k = (65536 * (s - e) + s - 1) / s;
         shape_table[2 * SPAN + p] = frac_code(k);
      end

      fx_mode = les_pkg::MODE_OFF;
      fx_elapsed = 32'd0;
      fx_interval = 32'd0;
      fx_level = 8'd0;
      fx_peak = 8'd255;
      fx_phase = 0;
      fx_wave = les_pkg::WAVE_GAUSS;
      fx_duty = 8'd0;

      // directed: extremes, every opcode, timer and level corner cases
      add_cmd(les_pkg::OP_SET_PEAK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_SET_PEAK, 32'hFFFF_FFFF, les_pkg::WAVE_NONE, 8'd255, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'hFFFF_FFFF, les_pkg::WAVE_NONE, 8'd255, 1'b0);
      add_cmd(les_pkg::OP_ON, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_ON, 32'd1, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_BLINK, 32'd2, les_pkg::WAVE_CIRCLE, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_BLINK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_SET_PEAK, 32'd0, les_pkg::WAVE_GAUSS, 8'd100, 1'b0);
      add_cmd(les_pkg::OP_OFF, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_FADE_ON, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_FADE_OFF, 32'hFFFF_FFFF, les_pkg::WAVE_CIRCLE, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_BREATHE, 32'd0, les_pkg::WAVE_NONE, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_BREATHE, 32'd500, les_pkg::WAVE_TRIANGLE, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_TICK, 32'd0, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_FADE_ON, 32'hFFFF_FFFF, les_pkg::WAVE_NONE, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_BLINK, 32'hFFFF_FFFF, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);
      add_cmd(les_pkg::OP_ON, 32'hFFFF_FFFF, les_pkg::WAVE_GAUSS, 8'd0, 1'b0);

      // random: a command followed by a run of ticks, with stray items mixed in
      mid_drained = 1'b0;
      while (led_cmds.size() < 1900) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) op = les_pkg::OP_ON;
         else if (pick < 3) op = les_pkg::OP_OFF;
         else if (pick < 7) op = les_pkg::OP_FADE_ON;
         else if (pick < 10) op = les_pkg::OP_FADE_OFF;
         else if (pick < 13) op = les_pkg::OP_BLINK;
         else if (pick < 16) op = les_pkg::OP_BREATHE;
         else if (pick < 18) op = les_pkg::OP_SET_PEAK;
         else op = les_pkg::opcode_type'($urandom_range(0, 7));
         if ($urandom_range(0, 9) == 0) begin
            dur = $urandom();
         end else begin
            case (op)
               les_pkg::OP_FADE_ON, les_pkg::OP_FADE_OFF:
                  dur = $urandom_range(0, 1) ? $urandom_range(0, 499) : $urandom_range(500, 1600);
               les_pkg::OP_BREATHE: dur = $urandom_range(0, 3200);
               default: dur = $urandom_range(0, 12);
            endcase
         end
         add_cmd(op, dur, 2'($urandom_range(0, 3)), 8'($urandom()),
                 led_cmds.size() == 25 || (!mid_drained && led_cmds.size() >= 1000));
         if (led_cmds.size() >= 1000) mid_drained = 1'b1;
         runs = $urandom_range(0, 3) == 0 ? $urandom_range(150, 300) : $urandom_range(1, 40);
         repeat (runs) begin
            if ($urandom_range(0, 29) == 0) begin
               add_cmd(les_pkg::opcode_type'($urandom_range(0, 7)), $urandom(),
                       2'($urandom_range(0, 3)), 8'($urandom()), 1'b0);
            end else begin
               add_cmd(les_pkg::OP_TICK, $urandom(), 2'($urandom_range(0, 3)), 8'($urandom()),
                       1'b0);
            end
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (led_cmds.size() != 0 || req_tvalid) @(negedge clock);
      while (led_outs_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
